FILE: rtl/core/pfrgd_pkg.sv
// Package for the page framebuffer drawer: shared types, action codes and
// default screen geometry. No dependencies.
`timescale 1ns / 1ps
package pfrgd_pkg;

  localparam int DefScreenWidth  = 128;
  localparam int DefScreenHeight = 64;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_GLYPH = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic        pixel_on;
    logic [34:0] glyph_bits;
    logic [3:0]  glyph_scale;
    logic [2:0]  read_page;
    logic [6:0]  read_column;
  } item_t;

endpackage

FILE: rtl/core/pfrgd_front.sv
// Front part of the drawer: accepts input beats and queues them for the back part.
// Depends on pfrgd_pkg.
`timescale 1ns / 1ps
module pfrgd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pfrgd_pkg::item_t in_item_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output pfrgd_pkg::item_t q_item_o
);
  import pfrgd_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/pfrgd_back.sv
// Back part of the drawer: framebuffer memory, clearing sweep, rectangle and
// glyph walker with read-modify-write, byte read and result register.
// Depends on pfrgd_pkg.
`timescale 1ns / 1ps
module pfrgd_back #(
  parameter int SCREEN_WIDTH  = pfrgd_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = pfrgd_pkg::DefScreenHeight
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  pfrgd_pkg::item_t q_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_data_o
);
  import pfrgd_pkg::*;

  localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int Depth = Pages * SCREEN_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam logic signed [10:0] WS = 11'(SCREEN_WIDTH);
  localparam logic signed [10:0] HS = 11'(SCREEN_HEIGHT);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLR   = 10'b0000000010,
    ST_SETUP = 10'b0000000100,
    ST_RD    = 10'b0000001000,
    ST_WR    = 10'b0000010000,
    ST_DOT   = 10'b0000100000,
    ST_ADV   = 10'b0001000000,
    ST_RDB   = 10'b0010000000,
    ST_RDW   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e      state_q, state_d;
  item_t       it_q;
  logic        clr_item_q, clr_item_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [34:0] bits_q, bits_d;
  logic [5:0]  dot_q, dot_d;
  logic [2:0]  row_q, row_d;
  logic [6:0]  offx_q, offx_d, offy_q, offy_d;
  logic [7:0]  szw_q, szw_d, szh_q, szh_d;
  logic [8:0]  x0_q, x0_d, x1_q, x1_d;
  logic [6:0]  y0_q, y0_d, y1_q, y1_d;
  logic [7:0]  cx_q, cx_d;
  logic [2:0]  pg_q, pg_d, pgl_q, pgl_d;
  logic [7:0]  data_q, data_d;
  logic        res_valid_q;
  logic [7:0]  res_data_q;
  logic        res_load;

  logic [7:0]    mem_q [Depth];
  logic [7:0]    rdata_q;
  logic [AW-1:0] addr;
  logic          we;
  logic [7:0]    wdata;
  logic [7:0]    mask;

  logic signed [10:0] rx, ex, ry, ey, x0s, x1s, y0s, y1s, ylast;

  always_comb begin
    rx  = $signed({{2{it_q.pos_x[8]}}, it_q.pos_x}) + $signed({4'b0, offx_q});
    ex  = rx + $signed({3'b0, szw_q});
    ry  = $signed({{2{it_q.pos_y[8]}}, it_q.pos_y}) + $signed({4'b0, offy_q});
    ey  = ry + $signed({3'b0, szh_q});
    x0s = rx[10] ? 11'sd0 : rx;
    x1s = (ex > WS) ? WS : ex;
    y0s = ry[10] ? 11'sd0 : ry;
    y1s = (ey > HS) ? HS : ey;
    ylast = y1s - 11'sd1;
  end

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      mask[r] = ({1'b0, pg_q, 3'(r)} >= y0_q) && ({1'b0, pg_q, 3'(r)} < y1_q);
    end
  end

  assign wdata = it_q.pixel_on ? (rdata_q | mask) : (rdata_q & ~mask);

  always_comb begin
    addr = AW'(int'(pg_q) * SCREEN_WIDTH + int'(cx_q));
    we   = 1'b0;
    if (state_q == ST_CLR) begin
      addr = clr_addr_q;
      we   = 1'b1;
    end else if (state_q == ST_RDB) begin
      addr = AW'(int'(it_q.read_page) * SCREEN_WIDTH + int'(it_q.read_column));
    end else if (state_q == ST_WR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= (state_q == ST_CLR) ? 8'd0 : wdata;
    end
    rdata_q <= mem_q[addr];
  end

  assign res_load = (state_q == ST_OUT) && (!res_valid_q || !out_stall_i);
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d    = state_q;
    clr_item_d = clr_item_q;
    clr_addr_d = clr_addr_q;
    bits_d     = bits_q;
    dot_d      = dot_q;
    row_d      = row_q;
    offx_d     = offx_q;
    offy_d     = offy_q;
    szw_d      = szw_q;
    szh_d      = szh_q;
    x0_d       = x0_q;
    x1_d       = x1_q;
    y0_d       = y0_q;
    y1_d       = y1_q;
    cx_d       = cx_q;
    pg_d       = pg_q;
    pgl_d      = pgl_q;
    data_d     = data_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          data_d = 8'd0;
          bits_d = q_item_i.glyph_bits;
          dot_d  = 6'd0;
          row_d  = 3'd0;
          offx_d = 7'd0;
          offy_d = 7'd0;
          szw_d  = q_item_i.rect_width;
          szh_d  = q_item_i.rect_height;
          case (q_item_i.action)
            ACT_CLEAR: begin
              clr_item_d = 1'b1;
              clr_addr_d = '0;
              state_d    = ST_CLR;
            end
            ACT_FILL:  state_d = ST_SETUP;
            ACT_GLYPH: state_d = ST_DOT;
            default: begin
              if (int'(q_item_i.read_page) < Pages &&
                  int'(q_item_i.read_column) < SCREEN_WIDTH) begin
                state_d = ST_RDB;
              end else begin
                state_d = ST_OUT;
              end
            end
          endcase
        end
      end
      ST_CLR: begin
        if (clr_addr_q == AW'(Depth - 1)) begin
          state_d = clr_item_q ? ST_OUT : ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      ST_SETUP: begin
        if (x1s <= x0s || y1s <= y0s) begin
          state_d = (it_q.action == ACT_GLYPH) ? ST_ADV : ST_OUT;
        end else begin
          x0_d    = x0s[8:0];
          x1_d    = x1s[8:0];
          y0_d    = y0s[6:0];
          y1_d    = y1s[6:0];
          cx_d    = x0s[7:0];
          pg_d    = y0s[5:3];
          pgl_d   = ylast[5:3];
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_WR;
      ST_WR: begin
        state_d = ST_RD;
        if ({1'b0, cx_q} == x1_q - 9'd1) begin
          cx_d = x0_q[7:0];
          if (pg_q == pgl_q) begin
            state_d = (it_q.action == ACT_GLYPH) ? ST_ADV : ST_OUT;
          end else begin
            pg_d = pg_q + 3'd1;
          end
        end else begin
          cx_d = cx_q + 8'd1;
        end
      end
      ST_DOT: begin
        if (dot_q == 6'd35) begin
          state_d = ST_OUT;
        end else if (bits_q[0] && it_q.glyph_scale != 4'd0) begin
          szw_d   = {4'b0, it_q.glyph_scale};
          szh_d   = {4'b0, it_q.glyph_scale};
          state_d = ST_SETUP;
        end else begin
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        bits_d = bits_q >> 1;
        dot_d  = dot_q + 6'd1;
        if (row_q == 3'd6) begin
          row_d  = 3'd0;
          offy_d = 7'd0;
          offx_d = offx_q + {3'b0, it_q.glyph_scale};
        end else begin
          row_d  = row_q + 3'd1;
          offy_d = offy_q + {3'b0, it_q.glyph_scale};
        end
        state_d = ST_DOT;
      end
      ST_RDB: state_d = ST_RDW;
      ST_RDW: begin
        data_d  = rdata_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    bits_q     <= bits_d;
    dot_q      <= dot_d;
    row_q      <= row_d;
    offx_q     <= offx_d;
    offy_q     <= offy_d;
    szw_q      <= szw_d;
    szh_q      <= szh_d;
    x0_q       <= x0_d;
    x1_q       <= x1_d;
    y0_q       <= y0_d;
    y1_q       <= y1_d;
    cx_q       <= cx_d;
    pg_q       <= pg_d;
    pgl_q      <= pgl_d;
    data_q     <= data_d;
    if (res_load) res_data_q <= data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_item_q  <= 1'b0;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_item_q <= clr_item_d;
      clr_addr_q <= clr_addr_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign read_data_o = res_data_q;

endmodule

FILE: rtl/core/page_framebuffer_rect_glyph_drawer_top.sv
// Top level of the page framebuffer drawer: front queue and back engine.
// Depends on pfrgd_pkg, pfrgd_front and pfrgd_back.
`timescale 1ns / 1ps
// After reset the block sweeps the framebuffer of Pages*SCREEN_WIDTH bytes
// (1024 by default) to zero, and the engine takes no item meanwhile. Each
// item gives one result beat. A read fetches one framebuffer byte and a clear
// sweeps every framebuffer byte to zero. A fill visits each framebuffer byte
// it touches, and the single memory port does one read and one write per
// byte. A glyph walks its 35 dots and draws a scaled square for each set dot
// when the scale is not zero. A queue of two items lets input beats be
// accepted while the engine works.
module page_framebuffer_rect_glyph_drawer_top #(
  parameter int SCREEN_WIDTH  = pfrgd_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = pfrgd_pkg::DefScreenHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [8:0]  pos_x_i,
  input  logic [8:0]  pos_y_i,
  input  logic [7:0]  rect_width_i,
  input  logic [7:0]  rect_height_i,
  input  logic        pixel_on_i,
  input  logic [34:0] glyph_bits_i,
  input  logic [3:0]  glyph_scale_i,
  input  logic [2:0]  read_page_i,
  input  logic [6:0]  read_column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o
);
  import pfrgd_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  always_comb begin
    in_item.action      = action_e'(action_i);
    in_item.pos_x       = pos_x_i;
    in_item.pos_y       = pos_y_i;
    in_item.rect_width  = rect_width_i;
    in_item.rect_height = rect_height_i;
    in_item.pixel_on    = pixel_on_i;
    in_item.glyph_bits  = glyph_bits_i;
    in_item.glyph_scale = glyph_scale_i;
    in_item.read_page   = read_page_i;
    in_item.read_column = read_column_i;
  end

  pfrgd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  pfrgd_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

FILE: rtl/core/pfrgd_checker.sv
// Port-level checker for the page framebuffer drawer, bound to the top level.
// Depends on page_framebuffer_rect_glyph_drawer_top.
`timescale 1ns / 1ps
module pfrgd_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);
  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result beat during reset");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result beat without an accepted item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more items in flight than the block can hold");

endmodule

bind page_framebuffer_rect_glyph_drawer_top pfrgd_port_checker u_pfrgd_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);

FILE: tb/sv/pfrgd_checker.sv
// Checker for the page framebuffer drawer: mirrors the framebuffer, predicts
// each read byte and compares result beats in order. Depends on pfrgd_pkg.
`timescale 1ns / 1ps
module pfrgd_checker #(
  parameter int SCREEN_WIDTH  = pfrgd_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = pfrgd_pkg::DefScreenHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [8:0]  pos_x_i,
  input  logic [8:0]  pos_y_i,
  input  logic [7:0]  rect_width_i,
  input  logic [7:0]  rect_height_i,
  input  logic        pixel_on_i,
  input  logic [34:0] glyph_bits_i,
  input  logic [3:0]  glyph_scale_i,
  input  logic [2:0]  read_page_i,
  input  logic [6:0]  read_column_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  read_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import pfrgd_pkg::*;

  localparam int Pages = (SCREEN_HEIGHT + 7) / 8;

  logic [7:0] shadow_fb [Pages][SCREEN_WIDTH];
  logic [7:0] expected_bytes [$];

  function automatic void shadow_clear();
    foreach (shadow_fb[p, c]) shadow_fb[p][c] = '0;
  endfunction

  function automatic void shadow_rect(int x, int y, int w, int h, logic on);
    int x0, y0, x1, y1;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
    y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
    for (int j = y0; j < y1; j++) begin
      for (int i = x0; i < x1; i++) begin
        shadow_fb[j / 8][i][j % 8] = on;
      end
    end
  endfunction

  function automatic logic [7:0] predict_beat(action_e act, int x, int y, int w, int h,
                                              logic on, logic [34:0] bits, int scale,
                                              int page, int column);
    logic [7:0] data;
    data = '0;
    case (act)
      ACT_CLEAR: shadow_clear();
      ACT_FILL: shadow_rect(x, y, w, h, on);
      ACT_GLYPH: begin
        for (int c = 0; c < 5; c++) begin
          for (int r = 0; r < 7; r++) begin
            if (bits[c * 7 + r]) shadow_rect(x + c * scale, y + r * scale, scale, scale, on);
          end
        end
      end
      default: begin
        if (page < Pages && column < SCREEN_WIDTH) data = shadow_fb[page][column];
      end
    endcase
    return data;
  endfunction

  initial begin
    shadow_clear();
    fail_count_o = 0;
  end

  assign pending_o = expected_bytes.size();

  always @(posedge clk_i) begin
    logic [7:0] exp_byte;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      expected_bytes.push_back(predict_beat(action_e'(action_i), int'($signed(pos_x_i)),
        int'($signed(pos_y_i)), int'(rect_width_i), int'(rect_height_i), pixel_on_i,
        glyph_bits_i, int'(glyph_scale_i), int'(read_page_i), int'(read_column_i)));
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10) $display("Unexpected result beat: read_data %h", read_data_i);
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (exp_byte !== read_data_i) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) begin
            $display("read_data differs: expected %h, got %h", exp_byte, read_data_i);
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the page framebuffer drawer: drives directed and random
// beats with random idling. Depends on pfrgd_pkg, the block and pfrgd_checker.
`timescale 1ns / 1ps
module tb_top;
  import pfrgd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_READ;
  logic [8:0]  pos_x_i = '0;
  logic [8:0]  pos_y_i = '0;
  logic [7:0]  rect_width_i = '0;
  logic [7:0]  rect_height_i = '0;
  logic        pixel_on_i = 1'b0;
  logic [34:0] glyph_bits_i = '0;
  logic [3:0]  glyph_scale_i = '0;
  logic [2:0]  read_page_i = '0;
  logic [6:0]  read_column_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_data_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 73;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  page_framebuffer_rect_glyph_drawer_top dut (.*);

  pfrgd_checker watcher (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .pos_x_i, .pos_y_i,
    .rect_width_i, .rect_height_i, .pixel_on_i, .glyph_bits_i, .glyph_scale_i,
    .read_page_i, .read_column_i, .out_valid_i(out_valid_o), .out_stall_i,
    .read_data_i(read_data_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_beat(action_e act, logic [8:0] x, logic [8:0] y, logic [7:0] w,
                           logic [7:0] h, logic on, logic [34:0] bits, logic [3:0] scale,
                           logic [2:0] page, logic [6:0] column);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    pos_x_i <= x;
    pos_y_i <= y;
    rect_width_i <= w;
    rect_height_i <= h;
    pixel_on_i <= on;
    glyph_bits_i <= bits;
    glyph_scale_i <= scale;
    read_page_i <= page;
    read_column_i <= column;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_read(int page, int column);
    send_beat(ACT_READ, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 35'({$urandom, $urandom}), 4'($urandom), 3'(page),
              7'(column));
  endtask

  task automatic send_random();
    int pick;
    logic [8:0] x, y;
    logic [3:0] scale;
    pick = $urandom_range(99);
    x = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($signed($urandom_range(150)) - 20);
    y = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($signed($urandom_range(90)) - 20);
    scale = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(3));
    if (pick < 2) begin
      send_beat(ACT_CLEAR, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 35'({$urandom, $urandom}), 4'($urandom), 3'($urandom),
                7'($urandom));
    end else if (pick < 25) begin
      send_beat(ACT_FILL, x, y,
                ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(24)),
                ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(24)),
                ($urandom_range(3) != 0), 35'({$urandom, $urandom}), 4'($urandom),
                3'($urandom), 7'($urandom));
    end else if (pick < 40) begin
      send_beat(ACT_GLYPH, x, y, 8'($urandom), 8'($urandom), ($urandom_range(3) != 0),
                35'({$urandom, $urandom}), scale, 3'($urandom), 7'($urandom));
    end else begin
      send_beat(ACT_READ, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 35'({$urandom, $urandom}), 4'($urandom), 3'($urandom),
                7'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_read(0, 0);
    send_beat(ACT_FILL, 9'h1f0, 9'h1f0, 8'd255, 8'd255, 1'b1, '0, 4'd1, '0, '0);
    send_read(7, 127);
    send_read(3, 64);
    send_beat(ACT_FILL, 9'd3, 9'd5, 8'd0, 8'd10, 1'b0, '0, 4'd1, '0, '0);
    send_beat(ACT_FILL, 9'd10, 9'd2, 8'd20, 8'd0, 1'b0, '0, 4'd1, '0, '0);
    send_beat(ACT_FILL, 9'd10, 9'd3, 8'd20, 8'd9, 1'b0, '0, 4'd1, '0, '0);
    send_read(0, 15);
    send_read(1, 15);
    send_beat(ACT_CLEAR, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    send_read(7, 127);
    send_beat(ACT_GLYPH, 9'd0, 9'd0, '0, '0, 1'b1, {35{1'b1}}, 4'd1, '0, '0);
    send_read(0, 4);
    send_beat(ACT_GLYPH, 9'd120, 9'd60, '0, '0, 1'b1, 35'h555555555, 4'd8, '0, '0);
    send_beat(ACT_GLYPH, 9'd40, 9'd8, '0, '0, 1'b1, 35'h7ffffffff, 4'd0, '0, '0);
    send_beat(ACT_GLYPH, 9'h100, 9'h100, '0, '0, 1'b1, 35'h2aaaaaaaa, 4'd15, '0, '0);
    send_beat(ACT_GLYPH, 9'd2, 9'd1, '0, '0, 1'b0, 35'h7ffffffff, 4'd1, '0, '0);
    send_read(0, 2);
    send_read(7, 120);
    send_read(5, 40);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (int n = 0; n < 1830; n++) begin
      if (n == 600) begin
        send_idle_pct = 73;
        recv_idle_pct = 16;
      end else if (n == 1200) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2000) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
